### rtl/tcw_pkg.sv
`timescale 1ns / 1ps

package tcw_pkg;

   localparam logic [1:0] KIND_PUT   = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
   localparam logic [7:0]  BLANK_CODE   = 8'h20;
   localparam logic [7:0]  RESET_COLOR  = 8'h07;
   localparam logic [15:0] RESET_CELL   = 16'h0720;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  char_code;
      logic [10:0] cell_address;
   } req_type;

   typedef struct packed {
      logic [15:0] cell_value;
      logic [10:0] cursor_pos;
      logic        scrolled;
   } rsp_type;

   typedef struct packed {
      logic    load;
      rsp_type data;
   } rsp_load_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_COPY,
      ST_DRAIN,
      ST_FILL,
      ST_FINISH
   } seq_state_type;

endpackage

### rtl/tcw_screen_mem.sv
`timescale 1ns / 1ps

module tcw_screen_mem #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [15:0]   rd_data
);

   logic [15:0] mem_ff [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tcw_seq.sv
`timescale 1ns / 1ps

module tcw_seq #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25,
   localparam int CELLS  = COLUMNS * ROWS,
   localparam int AW     = $clog2(CELLS)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  tcw_pkg::req_type      req,
   output logic                  req_ready,
   input  logic                  rsp_free,
   input  logic [7:0]            text_color,
   output logic                  mem_wr_en,
   output logic [AW-1:0]         mem_wr_addr,
   output logic [15:0]           mem_wr_data,
   output logic                  mem_rd_en,
   output logic [AW-1:0]         mem_rd_addr,
   input  logic [15:0]           mem_rd_data,
   output tcw_pkg::rsp_load_type rsp_load
);

   localparam int CW   = (AW + 1 > 12) ? AW + 1 : 12;
   localparam int COLW = $clog2(COLUMNS);

   tcw_pkg::seq_state_type state_ff, state_in;

   logic [AW-1:0]   cnt_ff, cnt_in;
   logic [AW-1:0]   cursor_ff, cursor_in;
   logic [COLW-1:0] col_ff, col_in;
   logic            cp_v_ff, cp_v_in;
   logic [AW-1:0]   cp_addr_ff, cp_addr_in;
   logic            pend_read_ff, pend_read_in;
   logic            pend_scroll_ff, pend_scroll_in;

   logic            accept;
   logic            is_newline;
   logic            in_range;
   logic            do_scroll;
   logic            cnt_last;
   logic [CW-1:0]   step_w;
   logic [CW-1:0]   sum_w;
   logic [AW-1:0]   cursor_new;
   logic [COLW-1:0] col_new;
   logic [10:0]     cursor_out;

   assign accept     = req_valid && req_ready;
   assign is_newline = (req.char_code == tcw_pkg::NEWLINE_CODE);
   assign in_range   = CW'(req.cell_address) < CW'(CELLS);
   assign cnt_last   = (cnt_ff == AW'(CELLS - 1));
   assign cursor_out = 11'(CW'(cursor_ff));

   always_comb begin
      step_w     = is_newline ? (CW'(COLUMNS) - CW'(col_ff)) : CW'(1);
      sum_w      = CW'(cursor_ff) + step_w;
      do_scroll  = (sum_w >= CW'(CELLS));
      cursor_new = do_scroll ? AW'(sum_w - CW'(COLUMNS)) : AW'(sum_w);
      if (is_newline || (col_ff == COLW'(COLUMNS - 1))) begin
         col_new = '0;
      end else begin
         col_new = col_ff + 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcw_pkg::ST_INIT: begin
            if (cnt_last) state_in = tcw_pkg::ST_IDLE;
         end
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               case (req.kind)
                  tcw_pkg::KIND_PUT: begin
                     if (do_scroll) state_in = tcw_pkg::ST_COPY;
                  end
                  tcw_pkg::KIND_CLEAR: state_in = tcw_pkg::ST_FILL;
                  tcw_pkg::KIND_READ: begin
                     if (in_range) state_in = tcw_pkg::ST_FINISH;
                  end
                  default: state_in = tcw_pkg::ST_IDLE;
               endcase
            end
         end
         tcw_pkg::ST_COPY: begin
            if (cnt_last) state_in = tcw_pkg::ST_DRAIN;
         end
         tcw_pkg::ST_DRAIN: state_in = tcw_pkg::ST_FILL;
         tcw_pkg::ST_FILL: begin
            if (cnt_last) state_in = tcw_pkg::ST_FINISH;
         end
         tcw_pkg::ST_FINISH: begin
            if (rsp_free) state_in = tcw_pkg::ST_IDLE;
         end
         default: state_in = tcw_pkg::ST_INIT;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = '0;
      mem_wr_data   = '0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;
      rsp_load      = '0;
      case (state_ff)
         tcw_pkg::ST_INIT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff;
            mem_wr_data = tcw_pkg::RESET_CELL;
         end
         tcw_pkg::ST_IDLE: begin
            req_ready = rsp_free;
            rsp_load.data.cursor_pos = cursor_out;
            if (accept) begin
               case (req.kind)
                  tcw_pkg::KIND_PUT: begin
                     mem_wr_en   = !is_newline;
                     mem_wr_addr = cursor_ff;
                     mem_wr_data = {text_color, req.char_code};
                     rsp_load.load = !do_scroll;
                     rsp_load.data.cursor_pos = 11'(CW'(cursor_new));
                  end
                  tcw_pkg::KIND_CLEAR: rsp_load.load = 1'b0;
                  tcw_pkg::KIND_READ: begin
                     mem_rd_en     = in_range;
                     mem_rd_addr   = AW'(CW'(req.cell_address));
                     rsp_load.load = !in_range;
                  end
                  default: rsp_load.load = 1'b1;
               endcase
            end
         end
         tcw_pkg::ST_COPY: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = cnt_ff;
            mem_wr_en   = cp_v_ff;
            mem_wr_addr = cp_addr_ff;
            mem_wr_data = mem_rd_data;
         end
         tcw_pkg::ST_DRAIN: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cp_addr_ff;
            mem_wr_data = mem_rd_data;
         end
         tcw_pkg::ST_FILL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff;
            mem_wr_data = {text_color, tcw_pkg::BLANK_CODE};
         end
         tcw_pkg::ST_FINISH: begin
            rsp_load.load            = rsp_free;
            rsp_load.data.cell_value = pend_read_ff ? mem_rd_data : 16'd0;
            rsp_load.data.cursor_pos = cursor_out;
            rsp_load.data.scrolled   = pend_scroll_ff;
         end
         default: rsp_load = '0;
      endcase
   end

   always_comb begin
      cnt_in         = cnt_ff;
      cursor_in      = cursor_ff;
      col_in         = col_ff;
      cp_v_in        = (state_ff == tcw_pkg::ST_COPY);
      cp_addr_in     = cnt_ff - AW'(COLUMNS);
      pend_read_in   = pend_read_ff;
      pend_scroll_in = pend_scroll_ff;
      case (state_ff)
         tcw_pkg::ST_INIT: begin
            if (!cnt_last) cnt_in = cnt_ff + 1'b1;
         end
         tcw_pkg::ST_IDLE: begin
            if (accept) begin
               pend_read_in   = 1'b0;
               pend_scroll_in = 1'b0;
               case (req.kind)
                  tcw_pkg::KIND_PUT: begin
                     cursor_in      = cursor_new;
                     col_in         = col_new;
                     cnt_in         = AW'(COLUMNS);
                     pend_scroll_in = do_scroll;
                  end
                  tcw_pkg::KIND_CLEAR: begin
                     cursor_in = '0;
                     col_in    = '0;
                     cnt_in    = '0;
                  end
                  tcw_pkg::KIND_READ: pend_read_in = in_range;
                  default: pend_read_in = 1'b0;
               endcase
            end
         end
         tcw_pkg::ST_COPY: begin
            cnt_in = cnt_last ? AW'(CELLS - COLUMNS) : cnt_ff + 1'b1;
         end
         tcw_pkg::ST_FILL: begin
            if (!cnt_last) cnt_in = cnt_ff + 1'b1;
         end
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= tcw_pkg::ST_INIT;
         cnt_ff         <= '0;
         cursor_ff      <= '0;
         col_ff         <= '0;
         cp_v_ff        <= 1'b0;
         pend_read_ff   <= 1'b0;
         pend_scroll_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         cursor_ff      <= cursor_in;
         col_ff         <= col_in;
         cp_v_ff        <= cp_v_in;
         pend_read_ff   <= pend_read_in;
         pend_scroll_ff <= pend_scroll_in;
      end
   end

   always_ff @(posedge clock) begin
      cp_addr_ff <= cp_addr_in;
   end

endmodule

### rtl/text_console_writer_unit.sv
`timescale 1ns / 1ps

// Text console writer: a COLUMNS x ROWS screen of 16-bit cells (attribute byte
// over character code) held in one single-port-write, registered-read memory,
// plus a cursor. One word in gives one word out. A put that does not scroll and
// any unused or out-of-range item load the response register when taken; a
// read of a cell answers from the finish state after the registered read. A
// put that runs past the last cell scrolls: every row is copied up by one, a
// drain step and a blank-fill of the last row follow, then the response; a
// clear blank-fills the whole screen, then responds; the memory takes one
// write per cycle. Reset blanks the screen to 0x0720, req_ready low; csr writes
// are taken at any time, but should only be done while the block is idle.
module text_console_writer_unit #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tcw_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tcw_pkg::rsp_type rsp,
   input  logic             csr_write_enable,
   input  logic [7:0]       csr_write_data
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);

   logic [7:0]            color_ff, color_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_type      rsp_data_ff, rsp_data_in;
   logic                  rsp_free;
   tcw_pkg::rsp_load_type rsp_load;

   logic          mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   logic [15:0]   mem_wr_data;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic [15:0]   mem_rd_data;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      color_in     = csr_write_enable ? csr_write_data : color_ff;
      rsp_data_in  = rsp_load.load ? rsp_load.data : rsp_data_ff;
      rsp_valid_in = rsp_load.load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff     <= tcw_pkg::RESET_COLOR;
         rsp_valid_ff <= 1'b0;
      end else begin
         color_ff     <= color_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_data_ff;

   tcw_seq #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req        (req),
      .req_ready  (req_ready),
      .rsp_free   (rsp_free),
      .text_color (color_ff),
      .mem_wr_en  (mem_wr_en),
      .mem_wr_addr(mem_wr_addr),
      .mem_wr_data(mem_wr_data),
      .mem_rd_en  (mem_rd_en),
      .mem_rd_addr(mem_rd_addr),
      .mem_rd_data(mem_rd_data),
      .rsp_load   (rsp_load)
   );

   tcw_screen_mem #(
      .DEPTH(CELLS),
      .AW   (AW)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

endmodule

### rtl/tcw_checker.sv
`timescale 1ns / 1ps

module tcw_checker #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tcw_pkg::rsp_type rsp
);

   localparam int CELLS = COLUMNS * ROWS;

   // word held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("rsp word changed while stalled");

   // blanking pass after reset keeps input closed
   a_init_closed: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req_ready high right after reset");

   a_scroll_no_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.scrolled |-> rsp.cell_value == 16'd0)
      else $error("scrolled word carries cell data");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CELLS > 2048) || (32'(rsp.cursor_pos) < CELLS))
      else $error("cursor beyond screen");

endmodule

bind text_console_writer_unit tcw_checker #(
   .COLUMNS(COLUMNS),
   .ROWS   (ROWS)
) u_tcw_checker (
   .clock    (clock),
   .reset    (reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp      (rsp)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import tcw_pkg::*;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   localparam logic [1:0] KIND_UNUSED = 2'd3;

   class screen_mirror;
      logic [15:0] cells [CELLS];
      int          cursor;
      logic [7:0]  text_color;
      rsp_type     answers [$];
      int          mismatch_count;

      function new();
         foreach (cells[i]) cells[i] = RESET_CELL;
         cursor         = 0;
         text_color     = RESET_COLOR;
         mismatch_count = 0;
      endfunction

      function int pending();
         return answers.size();
      endfunction

      function void accept_word(req_type w);
         rsp_type r;
         r = '0;
         if (cursor >= CELLS) cursor = 0;
         case (w.kind)
            KIND_PUT: begin
               if (w.char_code == NEWLINE_CODE) begin
                  cursor += COLUMNS - (cursor % COLUMNS);
               end else begin
                  cells[cursor] = {text_color, w.char_code};
                  cursor++;
               end
               if (cursor >= CELLS) begin
                  for (int i = 0; i < CELLS - COLUMNS; i++)
                     cells[i] = cells[i + COLUMNS];
                  for (int i = CELLS - COLUMNS; i < CELLS; i++)
                     cells[i] = {text_color, BLANK_CODE};
                  cursor -= COLUMNS;
                  r.scrolled = 1'b1;
               end
            end
            KIND_CLEAR: begin
               foreach (cells[i]) cells[i] = {text_color, BLANK_CODE};
               cursor = 0;
            end
            KIND_READ: begin
               if (w.cell_address < CELLS) r.cell_value = cells[w.cell_address];
            end
            default: ;
         endcase
         r.cursor_pos = cursor[10:0];
         answers.push_back(r);
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         if (answers.size() == 0) begin
            $error("response word with none expected: %h", got);
            mismatch_count++;
            return;
         end
         want = answers.pop_front();
         if (got.cell_value !== want.cell_value) begin
            $error("cell_value expected %h actual %h", want.cell_value, got.cell_value);
            mismatch_count++;
         end
         if (got.cursor_pos !== want.cursor_pos) begin
            $error("cursor_pos expected %0d actual %0d", want.cursor_pos, got.cursor_pos);
            mismatch_count++;
         end
         if (got.scrolled !== want.scrolled) begin
            $error("scrolled expected %b actual %b", want.scrolled, got.scrolled);
            mismatch_count++;
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;

   bit req_idle_on;
   bit rsp_stall_on;

   screen_mirror mirror = new();

   text_console_writer_unit #(
      .COLUMNS(COLUMNS),
      .ROWS(ROWS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req(req),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp(rsp),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // word accepted before response checked, in one process
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) mirror.accept_word(req);
         if (rsp_valid && rsp_ready) mirror.check_word(rsp);
      end
   end

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_stall_on && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      #(100_000_000);
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic req_type item(logic [1:0] kind, logic [7:0] code, logic [10:0] addr);
      req_type w;
      w.kind         = kind;
      w.char_code    = code;
      w.cell_address = addr;
      return w;
   endfunction

   function automatic req_type random_word();
      req_type w;
      int      pick;
      int      near;
      pick           = $urandom_range(0, 99);
      w.char_code    = 8'($urandom);
      w.cell_address = 11'($urandom);
      if (pick < 78) begin
         w.kind = KIND_PUT;
         if ($urandom_range(0, 11) == 0) w.char_code = NEWLINE_CODE;
      end else if (pick < 95) begin
         w.kind = KIND_READ;
         near   = mirror.cursor - int'($urandom_range(1, 160));
         case ($urandom_range(0, 9))
            0:       w.cell_address = 11'($urandom_range(CELLS, 2047));
            1, 2, 3: w.cell_address = 11'($urandom_range(0, CELLS - 1));
            default: w.cell_address = (near < 0) ? 11'd0 : near[10:0];
         endcase
      end else if (pick < 97) begin
         w.kind = KIND_CLEAR;
      end else begin
         w.kind = KIND_UNUSED;
      end
      return w;
   endfunction

   // called and returns at a falling edge
   task automatic send_word(input req_type w);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req       <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (mirror.pending() != 0) @(negedge clock);
   endtask

   task automatic write_color(input logic [7:0] color);
      csr_write_enable <= 1'b1;
      csr_write_data   <= color;
      @(negedge clock);
      csr_write_enable  <= 1'b0;
      mirror.text_color = color;
   endtask

   initial begin
      logic [7:0] colors [4];
      reset            = 1'b1;
      req_valid        = 1'b0;
      req              = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_idle_on      = 1'b0;
      rsp_stall_on     = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(item(KIND_READ, 8'h00, 11'd0));
      send_word(item(KIND_READ, 8'hFF, 11'd1999));
      send_word(item(KIND_READ, 8'h00, 11'd2000));
      send_word(item(KIND_READ, 8'hFF, 11'h7FF));
      send_word(item(KIND_UNUSED, 8'hFF, 11'h7FF));
      send_word(item(KIND_UNUSED, 8'h00, 11'd0));
      send_word(item(KIND_PUT, 8'h00, 11'h7FF));
      send_word(item(KIND_PUT, 8'hFF, 11'd0));
      send_word(item(KIND_PUT, 8'h41, 11'd0));
      send_word(item(KIND_PUT, NEWLINE_CODE, 11'd0));
      send_word(item(KIND_PUT, NEWLINE_CODE, 11'd0));
      for (int i = 0; i < 4; i++) send_word(item(KIND_READ, 8'h00, 11'(i)));
      send_word(item(KIND_CLEAR, 8'hFF, 11'h7FF));
      send_word(item(KIND_READ, 8'h00, 11'd0));
      send_word(item(KIND_READ, 8'h00, 11'd1999));
      send_word(item(KIND_PUT, 8'h42, 11'd0));
      send_word(item(KIND_READ, 8'h00, 11'd0));
      drain();

      colors[0] = 8'hFF;
      colors[1] = 8'h00;
      colors[2] = 8'($urandom);
      colors[3] = 8'($urandom);
      for (int phase = 0; phase < 4; phase++) begin
         write_color(colors[phase]);
         req_idle_on  = (phase == 0 || phase == 1);
         rsp_stall_on = (phase == 0 || phase == 2);
         for (int n = 0; n < 400; n++) send_word(random_word());
         drain();
      end

      repeat (2100) @(negedge clock);
      if (mirror.pending() != 0) begin
         $error("%0d response words never arrived", mirror.pending());
         mirror.mismatch_count++;
      end
      if (mirror.mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
